[hw/rtl/environment_sensor_compensation_unit_defines.svh]
// Assertion macros for the environment sensor compensation unit.
// Needs clk and rst in the scope where a macro is used.
`ifndef ENVIRONMENT_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define ENVIRONMENT_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ESC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define ESC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`else
`define ESC_ASSERT(lbl, prop)
`define ESC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[hw/rtl/esc_pkg.sv]
// Shared types and constants of the environment sensor compensation unit.
// No dependencies.
package esc_pkg;

  typedef enum logic [5:0] {
    S_IDLE, S_T0, S_T1, S_T2, S_T3,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_DIV, S_P9F,
    S_P10, S_P11, S_P12, S_P13,
    S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    REG_TEMP_TRIM       = 3'd0,
    REG_PRESS_TRIM_LOW  = 3'd1,
    REG_PRESS_TRIM_HIGH = 3'd2,
    REG_PRESS_HUM_TRIM  = 3'd3,
    REG_HUM_TRIM        = 3'd4
  } reg_idx_t;

  localparam logic [19:0] RAW_TP_OFF  = 20'h80000;
  localparam logic [15:0] RAW_H_OFF   = 16'h8000;
  localparam logic [31:0] HUM_MAX     = 32'd419430400;
  localparam int          DIV_STEPS   = 32;

endpackage

[hw/rtl/environment_sensor_compensation_unit.sv]
// Environment sensor compensation unit: top level with APB trim registers,
// one shared 32x32 multiplier under a sequencer and a radix-2 divider.
// Depends on esc_pkg and environment_sensor_compensation_unit_defines.svh.

// One word of raw temperature, pressure and humidity goes in; one word of
// compensated values comes out. Work is done one word at a time: temperature,
// then pressure with the bit-per-cycle divider, then humidity, each on the
// single shared multiplier. A disabled channel is skipped and reads zero.
// The fine temperature term is kept across words and reused when the
// temperature channel is off. A finished word waits in the output register
// while the next one is being computed.
`include "environment_sensor_compensation_unit_defines.svh"

module environment_sensor_compensation_unit import esc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        raw_temperature,
  input  logic [19:0]        raw_pressure,
  input  logic [15:0]        raw_humidity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_pa,
  output logic [16:0]        humidity_q10,
  output logic               temperature_valid,
  output logic               pressure_valid,
  output logic               humidity_valid
);

  function automatic logic [31:0] sar(input logic [31:0] v, input int n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  logic [47:0] temp_trim;
  logic [63:0] press_trim_low, press_trim_high;
  logic [47:0] press_hum_trim;
  logic [31:0] hum_trim;

  state_t state, state_next;
  logic [19:0] rt, rp_raw;
  logic [15:0] rh;
  logic tv, pv, hv;
  logic [31:0] ft, ra, rb, rc, rd, rp;
  logic [31:0] tres, pres;
  logic [16:0] hres;
  logic [31:0] quot;
  logic [32:0] rem;
  logic [4:0]  div_cnt;
  logic        div_low;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [32:0] rem_sh;
  logic [31:0] hum_v;
  logic        apb_wr;

  // Trim fields
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, temp_trim[15:0]};
  assign t2 = sx16(temp_trim[31:16]);
  assign t3 = sx16(temp_trim[47:32]);
  assign p1 = {16'd0, press_trim_low[15:0]};
  assign p2 = sx16(press_trim_low[31:16]);
  assign p3 = sx16(press_trim_low[47:32]);
  assign p4 = sx16(press_trim_low[63:48]);
  assign p5 = sx16(press_trim_high[15:0]);
  assign p6 = sx16(press_trim_high[31:16]);
  assign p7 = sx16(press_trim_high[47:32]);
  assign p8 = sx16(press_trim_high[63:48]);
  assign p9 = sx16(press_hum_trim[15:0]);
  assign h1 = {24'd0, press_hum_trim[23:16]};
  assign h2 = sx16(press_hum_trim[39:24]);
  assign h3 = {24'd0, press_hum_trim[47:40]};
  assign h4 = {20'd0, hum_trim[11:0]};
  assign h5 = {20'd0, hum_trim[23:12]};
  assign h6 = {{24{hum_trim[31]}}, hum_trim[31:24]};

  // APB register file
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim       <= '0;
      press_trim_low  <= '0;
      press_trim_high <= '0;
      press_hum_trim  <= '0;
      hum_trim        <= '0;
    end else if (apb_wr) begin
      case (paddr[5:3])
        REG_TEMP_TRIM:       temp_trim       <= pwdata[47:0];
        REG_PRESS_TRIM_LOW:  press_trim_low  <= pwdata;
        REG_PRESS_TRIM_HIGH: press_trim_high <= pwdata;
        REG_PRESS_HUM_TRIM:  press_hum_trim  <= pwdata[47:0];
        REG_HUM_TRIM:        hum_trim        <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_TEMP_TRIM:       prdata = {16'd0, temp_trim};
      REG_PRESS_TRIM_LOW:  prdata = press_trim_low;
      REG_PRESS_TRIM_HIGH: prdata = press_trim_high;
      REG_PRESS_HUM_TRIM:  prdata = {16'd0, press_hum_trim};
      REG_HUM_TRIM:        prdata = {32'd0, hum_trim};
      default:             prdata = '0;
    endcase
  end

  // Shared multiplier, low word only
  assign mul_p  = 32'(mul_a * mul_b);
  assign rem_sh = {rem[31:0], quot[31]};
  assign hum_v  = ra - sar(mul_p, 4);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (raw_temperature != RAW_TP_OFF) state_next = S_T0;
          else if (raw_pressure != RAW_TP_OFF) state_next = S_P0;
          else if (raw_humidity != RAW_H_OFF) state_next = S_H0;
          else state_next = S_DONE;
        end
      end
      S_T0: state_next = S_T1;
      S_T1: state_next = S_T2;
      S_T2: state_next = S_T3;
      S_T3: state_next = pv ? S_P0 : (hv ? S_H0 : S_DONE);
      S_P0: state_next = S_P1;
      S_P1: state_next = S_P2;
      S_P2: state_next = S_P3;
      S_P3: state_next = S_P4;
      S_P4: state_next = S_P5;
      S_P5: state_next = S_P6;
      S_P6: state_next = S_P7;
      S_P7: state_next = (sar(mul_p, 15) == 32'd0) ? (hv ? S_H0 : S_DONE) : S_P8;
      S_P8: state_next = S_P9;
      S_P9: state_next = S_DIV;
      S_DIV: state_next = (div_cnt == 5'(DIV_STEPS - 1)) ? S_P9F : S_DIV;
      S_P9F: state_next = S_P10;
      S_P10: state_next = S_P11;
      S_P11: state_next = S_P12;
      S_P12: state_next = S_P13;
      S_P13: state_next = hv ? S_H0 : S_DONE;
      S_H0: state_next = S_H1;
      S_H1: state_next = S_H2;
      S_H2: state_next = S_H3;
      S_H3: state_next = S_H4;
      S_H4: state_next = S_H5;
      S_H5: state_next = S_H6;
      S_H6: state_next = S_H7;
      S_H7: state_next = S_H8;
      S_H8: state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_T0: begin mul_a = {15'd0, rt[19:3]} - (t1 << 1); mul_b = t2; end
      S_T1: begin mul_a = {16'd0, rt[19:4]} - t1; mul_b = {16'd0, rt[19:4]} - t1; end
      S_T2: begin mul_a = rb; mul_b = t3; end
      S_T3: begin mul_a = ft; mul_b = 32'd5; end
      S_P1: begin mul_a = sar(ra, 2); mul_b = sar(ra, 2); end
      S_P2: begin mul_a = sar(rc, 11); mul_b = p6; end
      S_P3: begin mul_a = ra; mul_b = p5; end
      S_P5: begin mul_a = p3; mul_b = sar(rc, 13); end
      S_P6: begin mul_a = p2; mul_b = ra; end
      S_P7: begin mul_a = 32'd32768 + ra; mul_b = p1; end
      S_P8: begin
        mul_a = (32'd1048576 - {12'd0, rp_raw}) - sar(rb, 12);
        mul_b = 32'd3125;
      end
      S_P10: begin mul_a = rp >> 3; mul_b = rp >> 3; end
      S_P11: begin mul_a = p9; mul_b = rc; end
      S_P12: begin mul_a = rp >> 2; mul_b = p8; end
      S_H1: begin mul_a = h5; mul_b = ra; end
      S_H2: begin mul_a = ra; mul_b = h6; end
      S_H3: begin mul_a = ra; mul_b = h3; end
      S_H4: begin mul_a = rc; mul_b = rd; end
      S_H5: begin mul_a = rc; mul_b = h2; end
      S_H6: begin mul_a = rb; mul_b = rc; end
      S_H7: begin mul_a = sar(ra, 15); mul_b = sar(ra, 15); end
      S_H8: begin mul_a = rb; mul_b = h1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ft        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_T2: ft <= ra + sar(mul_p, 14);
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rt     <= raw_temperature;
        rp_raw <= raw_pressure;
        rh     <= raw_humidity;
        tv     <= raw_temperature != RAW_TP_OFF;
        pv     <= raw_pressure != RAW_TP_OFF;
        hv     <= raw_humidity != RAW_H_OFF;
        tres   <= '0;
        pres   <= '0;
        hres   <= '0;
      end
      S_T0: ra <= sar(mul_p, 11);
      S_T1: rb <= sar(mul_p, 12);
      S_T3: tres <= sar(mul_p + 32'd128, 8);
      S_P0: ra <= sar(ft, 1) - 32'd64000;
      S_P1: rc <= mul_p;
      S_P2: rb <= mul_p;
      S_P3: rb <= rb + (mul_p << 1);
      S_P4: rb <= sar(rb, 2) + (p4 << 16);
      S_P5: rd <= sar(mul_p, 3);
      S_P6: ra <= sar(rd + sar(mul_p, 1), 18);
      S_P7: ra <= sar(mul_p, 15);
      S_P8: rp <= mul_p;
      S_P9: begin
        div_low <= !rp[31];
        quot    <= rp[31] ? rp : (rp << 1);
        rem     <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        div_cnt <= div_cnt + 5'd1;
        if (rem_sh >= {1'b0, ra}) begin
          rem  <= rem_sh - {1'b0, ra};
          quot <= {quot[30:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          quot <= {quot[30:0], 1'b0};
        end
      end
      S_P9F: rp <= div_low ? quot : (quot << 1);
      S_P10: rc <= mul_p >> 13;
      S_P11: ra <= sar(mul_p, 12);
      S_P12: rb <= sar(mul_p, 13);
      S_P13: pres <= rp + sar(ra + rb + p7, 4);
      S_H0: ra <= ft - 32'd76800;
      S_H1: rb <= sar((({16'd0, rh} << 14) - (h4 << 20) - mul_p) + 32'd16384, 15);
      S_H2: rc <= sar(mul_p, 10);
      S_H3: rd <= sar(mul_p, 11) + 32'd32768;
      S_H4: rc <= sar(mul_p, 10) + 32'd2097152;
      S_H5: rc <= sar(mul_p + 32'd8192, 14);
      S_H6: ra <= mul_p;
      S_H7: rb <= sar(mul_p, 7);
      S_H8: begin
        if (hum_v[31]) hres <= '0;
        else if (hum_v > HUM_MAX) hres <= 17'(HUM_MAX >> 12);
        else hres <= 17'(hum_v >> 12);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      temperature_centi <= $signed(tres);
      pressure_pa       <= pres;
      humidity_q10      <= hres;
      temperature_valid <= tv;
      pressure_valid    <= pv;
      humidity_valid    <= hv;
    end
  end

  assign in_ready = (state == S_IDLE);

  `ESC_ASSERT_IMP(a_accept_leaves_idle, state == S_IDLE && in_valid, ##1 state != S_IDLE)
  `ESC_ASSERT_IMP(a_result_from_done, $rose(out_valid), $past(state) == S_DONE)
  `ESC_ASSERT_IMP(a_hum_clamped, out_valid, humidity_q10 <= 17'd102400)
  `ESC_ASSERT_IMP(a_div_enters_clean, state == S_P9, ##1 (state == S_DIV && div_cnt == 5'd0))

endmodule
